### hw/rtl/wsps_pkg.sv
// Package for the multichannel WS2812 pulse serialiser.
// Sizes, reset values, register and item codes, shared structs. No dependencies.
`default_nettype none

package wsps_pkg;

  localparam int CHANNELS     = 4;
  localparam int MAX_LEDS     = 512;
  localparam int LED_AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LEN_W        = (LED_AW + 1 > 10) ? LED_AW + 1 : 10;
  localparam int BITS_PER_LED = 24;
  localparam int BIT_W        = 5;
  localparam int OUT_LANES    = 4;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_LED - 1);

  localparam logic [7:0] HT_ONE_RST    = 8'd67;
  localparam logic [7:0] HT_ZERO_RST   = 8'd33;
  localparam logic [9:0] STRIP_LEN_RST = 10'd8;
  localparam logic [7:0] GAP_SLOTS_RST = 8'd10;

  typedef enum logic [1:0] {
    REG_HT_ONE    = 2'd0,
    REG_HT_ZERO   = 2'd1,
    REG_STRIP_LEN = 2'd2,
    REG_GAP_SLOTS = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef logic [BITS_PER_LED-1:0] colour_t;

  typedef struct packed {
    logic [7:0] ht_one;
    logic [7:0] ht_zero;
    logic [9:0] strip_len;
    logic [7:0] gap_slots;
  } cfg_t;

  typedef struct packed {
    logic             gap;
    logic             frame_end;
    logic [BIT_W-1:0] shift;
  } tick_info_t;

  typedef struct packed {
    logic              busy;
    logic [LED_AW-1:0] addr;
  } clr_t;

endpackage

`default_nettype wire

### hw/rtl/wsps_in_if.sv
// Input channel: colour writes and bit-period ticks.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface wsps_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] channel;
  logic [8:0] led_index;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;

  modport source (output valid, kind, channel, led_index, green, red, blue, input ready);
  modport sink   (input valid, kind, channel, led_index, green, red, blue, output ready);
endinterface

`default_nettype wire

### hw/rtl/wsps_out_if.sv
// Result channel: per-channel high times plus gap and frame-end flags.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface wsps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pulse_ch0;
  logic [7:0] pulse_ch1;
  logic [7:0] pulse_ch2;
  logic [7:0] pulse_ch3;
  logic       gap_flag;
  logic       frame_end;

  modport source (output valid, pulse_ch0, pulse_ch1, pulse_ch2, pulse_ch3, gap_flag,
                  frame_end, input ready);
  modport sink   (input valid, pulse_ch0, pulse_ch1, pulse_ch2, pulse_ch3, gap_flag,
                  frame_end, output ready);
endinterface

`default_nettype wire

### hw/rtl/wsps_cfg_if.sv
// Configuration write channel: register index and write data.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface wsps_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/wsps_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module wsps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wsps_cfg.sv
// Configuration register file: bit high times, strip length, gap length.
// Depends on wsps_pkg and wsps_cfg_if.
`default_nettype none

module wsps_cfg (
  input  wire logic      clk,
  input  wire logic      rst_n,
  wsps_cfg_if.sink       cfg_if,
  output wsps_pkg::cfg_t cfg
);

  wsps_pkg::cfg_t cfg_r;
  wsps_pkg::cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (wsps_pkg::cfg_reg_t'(cfg_if.index))
        wsps_pkg::REG_HT_ONE:    cfg_nxt.ht_one    = cfg_if.data[7:0];
        wsps_pkg::REG_HT_ZERO:   cfg_nxt.ht_zero   = cfg_if.data[7:0];
        wsps_pkg::REG_STRIP_LEN: cfg_nxt.strip_len = cfg_if.data;
        wsps_pkg::REG_GAP_SLOTS: cfg_nxt.gap_slots = cfg_if.data[7:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ht_one    <= wsps_pkg::HT_ONE_RST;
      cfg_r.ht_zero   <= wsps_pkg::HT_ZERO_RST;
      cfg_r.strip_len <= wsps_pkg::STRIP_LEN_RST;
      cfg_r.gap_slots <= wsps_pkg::GAP_SLOTS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wsps_seq.sv
// Frame sequencer: LED, bit and gap counters, colour store read address,
// and the post-reset clearing sweep. Depends on wsps_pkg.
`default_nettype none

module wsps_seq (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           tick_fire,
  input  wire wsps_pkg::cfg_t                 cfg,
  output wsps_pkg::tick_info_t                info,
  output logic [wsps_pkg::LED_AW-1:0]         rd_addr,
  output wsps_pkg::clr_t                      clr
);

  localparam logic [wsps_pkg::LED_AW-1:0] LAST_LED_ADDR =
    wsps_pkg::LED_AW'(wsps_pkg::MAX_LEDS - 1);

  logic                          gap_r,   gap_nxt;
  logic [wsps_pkg::LED_AW-1:0]   led_r,   led_nxt;
  logic [wsps_pkg::BIT_W-1:0]    bit_r,   bit_nxt;
  logic [7:0]                    gcnt_r,  gcnt_nxt;
  logic                          busy_r,  busy_nxt;
  logic [wsps_pkg::LED_AW-1:0]   caddr_r, caddr_nxt;

  logic                          slot_done;
  logic                          last_led;
  logic [wsps_pkg::LEN_W-1:0]    led_inc;
  logic [7:0]                    gcnt_inc;
  logic [7:0]                    slots;

  always_comb begin
    led_inc   = wsps_pkg::LEN_W'(led_r) + wsps_pkg::LEN_W'(1);
    // strip_length zero falls out as last LED; over-long strips stop at the store end
    last_led  = (led_inc >= wsps_pkg::LEN_W'(cfg.strip_len)) || (led_r == LAST_LED_ADDR);
    slot_done = (bit_r == wsps_pkg::LAST_BIT);
    gcnt_inc  = gcnt_r + 8'd1;
    slots     = (cfg.gap_slots == 8'd0) ? 8'd1 : cfg.gap_slots;

    gap_nxt  = gap_r;
    led_nxt  = led_r;
    bit_nxt  = bit_r;
    gcnt_nxt = gcnt_r;

    if (tick_fire) begin
      bit_nxt = slot_done ? '0 : bit_r + wsps_pkg::BIT_W'(1);
      if (gap_r) begin
        if (slot_done) begin
          if (gcnt_inc >= slots) begin
            gap_nxt  = 1'b0;
            led_nxt  = '0;
            gcnt_nxt = '0;
          end else begin
            gcnt_nxt = gcnt_inc;
          end
        end
      end else if (slot_done) begin
        if (last_led) begin
          gap_nxt  = 1'b1;
          gcnt_nxt = '0;
          led_nxt  = '0;
        end else begin
          led_nxt = led_r + wsps_pkg::LED_AW'(1);
        end
      end
    end

    busy_nxt  = busy_r;
    caddr_nxt = caddr_r;
    if (busy_r) begin
      caddr_nxt = caddr_r + wsps_pkg::LED_AW'(1);
      if (caddr_r == LAST_LED_ADDR) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign info.gap       = gap_r;
  assign info.frame_end = !gap_r && last_led && slot_done;
  assign info.shift     = wsps_pkg::LAST_BIT - bit_r;
  assign rd_addr        = led_r;
  assign clr.busy       = busy_r;
  assign clr.addr       = caddr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= 1'b0;
      led_r   <= '0;
      bit_r   <= '0;
      gcnt_r  <= '0;
      busy_r  <= 1'b1;
      caddr_r <= '0;
    end else begin
      gap_r   <= gap_nxt;
      led_r   <= led_nxt;
      bit_r   <= bit_nxt;
      gcnt_r  <= gcnt_nxt;
      busy_r  <= busy_nxt;
      caddr_r <= caddr_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wsps_out.sv
// Output stage: holds tick info while the colour read lands, selects the
// high times and keeps the result register. Depends on wsps_pkg, wsps_out_if.
`default_nettype none

module wsps_out (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  tick_fire,
  input  wire wsps_pkg::tick_info_t  info,
  input  wire wsps_pkg::cfg_t        cfg,
  input  wire wsps_pkg::colour_t     rd_data [wsps_pkg::CHANNELS],
  output logic                       s1_adv,
  wsps_out_if.source                 out_if
);

  logic                  s1_valid_r;
  wsps_pkg::tick_info_t  s1_info_r;
  logic                  out_valid_r;
  logic [7:0]            pulse_r [wsps_pkg::OUT_LANES];
  logic [7:0]            pulse_nxt [wsps_pkg::OUT_LANES];
  logic                  gap_r;
  logic                  fend_r;
  logic                  out_adv;

  assign out_adv = !out_valid_r || out_if.ready;
  assign s1_adv  = !s1_valid_r || out_adv;

  for (genvar g = 0; g < wsps_pkg::OUT_LANES; g++) begin : g_lane
    if (g < wsps_pkg::CHANNELS) begin : g_used
      assign pulse_nxt[g] = s1_info_r.gap ? 8'd0 :
                            (rd_data[g][s1_info_r.shift] ? cfg.ht_one : cfg.ht_zero);
    end else begin : g_unused
      assign pulse_nxt[g] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= tick_fire;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && tick_fire) begin
      s1_info_r <= info;
    end
    if (out_adv && s1_valid_r) begin
      pulse_r <= pulse_nxt;
      gap_r   <= s1_info_r.gap;
      fend_r  <= s1_info_r.frame_end;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.pulse_ch0 = pulse_r[0];
  assign out_if.pulse_ch1 = pulse_r[1];
  assign out_if.pulse_ch2 = pulse_r[2];
  assign out_if.pulse_ch3 = pulse_r[3];
  assign out_if.gap_flag  = gap_r;
  assign out_if.frame_end = fend_r;

endmodule

`default_nettype wire

### hw/rtl/ws2812_multichannel_pulse_serializer.sv
// WS2812 multichannel pulse serialiser: takes one item (colour write or bit-period
// tick) every cycle unless the result path stalls; a tick's result passes through the
// registered colour-store read and the result register. After reset a clearing sweep
// over all MAX_LEDS entries (512 as built) zeroes the colour store, during which no item is
// taken; configuration writes are always taken. Colours live in one RAM per channel.
// Depends on wsps_pkg, the three channel interfaces, wsps_cfg, wsps_seq, wsps_ram
// and wsps_out.
`default_nettype none

module ws2812_multichannel_pulse_serializer (
  input  wire logic clk,
  input  wire logic rst_n,
  wsps_in_if.sink    in_if,
  wsps_out_if.source out_if,
  wsps_cfg_if.sink   cfg_if
);

  wsps_pkg::cfg_t                cfg;
  wsps_pkg::tick_info_t          info;
  wsps_pkg::clr_t                clr;
  logic [wsps_pkg::LED_AW-1:0]   rd_addr;
  wsps_pkg::colour_t             rd_data [wsps_pkg::CHANNELS];
  logic                          s1_adv;
  logic                          in_fire;
  logic                          tick_fire;
  logic                          wr_fire;
  logic                          led_ok;
  logic [wsps_pkg::LED_AW-1:0]   waddr;
  wsps_pkg::colour_t             wdata;

  assign in_if.ready = !clr.busy && s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;
  assign tick_fire   = in_fire && (in_if.kind == wsps_pkg::KIND_TICK);
  assign led_ok      = (int'(in_if.led_index) < wsps_pkg::MAX_LEDS);
  assign wr_fire     = in_fire && (in_if.kind == wsps_pkg::KIND_WRITE) && led_ok;
  assign waddr       = clr.busy ? clr.addr : wsps_pkg::LED_AW'(in_if.led_index);
  assign wdata       = clr.busy ? '0 : {in_if.green, in_if.red, in_if.blue};

  wsps_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  wsps_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_fire (tick_fire),
    .cfg       (cfg),
    .info      (info),
    .rd_addr   (rd_addr),
    .clr       (clr)
  );

  for (genvar g = 0; g < wsps_pkg::CHANNELS; g++) begin : g_store
    logic we;
    assign we = clr.busy || (wr_fire && (int'(in_if.channel) == g));

    wsps_ram #(
      .WIDTH (wsps_pkg::BITS_PER_LED),
      .DEPTH (wsps_pkg::MAX_LEDS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (tick_fire),
      .raddr (rd_addr),
      .rdata (rd_data[g])
    );
  end

  wsps_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_fire (tick_fire),
    .info      (info),
    .cfg       (cfg),
    .rd_data   (rd_data),
    .s1_adv    (s1_adv),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

### dv/ws2812_multichannel_pulse_serializer_test.sv
// Self-checking bench for the multichannel WS2812 pulse serialiser: colour writes and
// bit-period ticks under several register settings, checked against a local predictor.
// Depends on wsps_pkg, the three channel interfaces and ws2812_multichannel_pulse_serializer.
`default_nettype none

module ws2812_multichannel_pulse_serializer_test;
  import wsps_pkg::*;

  localparam int IDLE_PCT       = 29;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_AFTER     = 150;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] channel;
    logic [8:0] led;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } strip_item_t;

  typedef struct packed {
    logic [OUT_LANES-1:0][7:0] pulse;
    logic                      gap;
    logic                      frame_end;
  } pulse_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  wsps_in_if  in_ch ();
  wsps_out_if out_ch ();
  wsps_cfg_if cfg_ch ();

  ws2812_multichannel_pulse_serializer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // serialiser mirror
  colour_t    led_colours [CHANNELS][MAX_LEDS];
  logic [7:0] ht_one;
  logic [7:0] ht_zero;
  logic [9:0] strip_len;
  logic [7:0] gap_slots;
  logic       in_gap;
  int         led_pos;
  int         bit_pos;
  logic [7:0] gap_count;

  strip_item_t tx_items [$];
  pulse_word_t pulse_fifo [$];

  int  errors       = 0;
  int  items_taken  = 0;
  int  writes_taken = 0;
  int  results_seen = 0;
  int  frame_ends   = 0;
  int  gap_ticks    = 0;
  int  settings     = 0;
  int  idle_cycles  = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  steady       = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void step_serialiser(strip_item_t it);
    pulse_word_t w;
    int          eff;
    logic        last;
    logic        slot_done;
    colour_t     c;
    w = '0;
    if (it.kind == KIND_WRITE) begin
      led_colours[it.channel][it.led] = {it.green, it.red, it.blue};
      writes_taken++;
      return;
    end
    slot_done = (bit_pos == BITS_PER_LED - 1);
    if (in_gap) begin
      w.gap = 1'b1;
      if (slot_done) begin
        gap_count = gap_count + 8'd1;
        if (gap_count >= ((gap_slots == 8'd0) ? 8'd1 : gap_slots)) begin
          in_gap    = 1'b0;
          led_pos   = 0;
          gap_count = 8'd0;
        end
      end
    end else begin
      eff  = (strip_len == 10'd0) ? 1 : (strip_len > MAX_LEDS) ? MAX_LEDS : int'(strip_len);
      last = (led_pos + 1 >= eff);
      for (int ch = 0; ch < OUT_LANES; ch++) begin
        if (ch < CHANNELS) begin
          c = led_colours[ch][led_pos % MAX_LEDS];
          w.pulse[ch] = c[BITS_PER_LED - 1 - bit_pos] ? ht_one : ht_zero;
        end
      end
      w.frame_end = last && slot_done;
      if (slot_done) begin
        if (last) begin
          in_gap    = 1'b1;
          gap_count = 8'd0;
          led_pos   = 0;
        end else begin
          led_pos++;
        end
      end
    end
    bit_pos = slot_done ? 0 : bit_pos + 1;
    pulse_fifo.push_back(w);
  endfunction

  function automatic strip_item_t colour_write(int ch, int led, logic [7:0] g, logic [7:0] r,
                                               logic [7:0] b);
    strip_item_t it;
    it.kind    = KIND_WRITE;
    it.channel = 2'(ch);
    it.led     = 9'(led);
    it.green   = g;
    it.red     = r;
    it.blue    = b;
    return it;
  endfunction

  // payload of a tick is don't-care, so it carries noise
  function automatic strip_item_t tick();
    strip_item_t it;
    it      = colour_write($urandom_range(3), $urandom_range(511), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)));
    it.kind = KIND_TICK;
    return it;
  endfunction

  task automatic fill_random(int n, int write_pct, int led_span);
    int led;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < write_pct) begin
        led = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(led_span - 1);
        tx_items.push_back(colour_write($urandom_range(3), led, 8'($urandom_range(255)),
                                        8'($urandom_range(255)), 8'($urandom_range(255))));
      end else begin
        tx_items.push_back(tick());
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [9:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_HT_ONE:    ht_one    = val[7:0];
      REG_HT_ZERO:   ht_zero   = val[7:0];
      REG_STRIP_LEN: strip_len = val;
      REG_GAP_SLOTS: gap_slots = val[7:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [9:0] one, logic [9:0] zero, logic [9:0] len, logic [9:0] gap);
    write_reg(REG_HT_ONE, one);
    write_reg(REG_HT_ZERO, zero);
    write_reg(REG_STRIP_LEN, len);
    write_reg(REG_GAP_SLOTS, gap);
    settings++;
  endtask

  // sender holds off until the block has returned every result and gone quiet;
  // sampled mid-cycle so the driver and receiver updates of the edge are settled
  task automatic drain();
    do @(negedge clk); while (tx_items.size() != 0 || in_ch.valid || pulse_fifo.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    strip_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (tx_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = tx_items.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= nxt.kind;
        in_ch.channel   <= nxt.channel;
        in_ch.led_index <= nxt.led;
        in_ch.green     <= nxt.green;
        in_ch.red       <= nxt.red;
        in_ch.blue      <= nxt.blue;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: checks results, mirrors accepted items, drives ready
  always @(posedge clk) begin
    pulse_word_t got;
    pulse_word_t want;
    strip_item_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.pulse     = {out_ch.pulse_ch3, out_ch.pulse_ch2, out_ch.pulse_ch1, out_ch.pulse_ch0};
        got.gap       = out_ch.gap_flag;
        got.frame_end = out_ch.frame_end;
        results_seen++;
        if (got.gap) gap_ticks++;
        if (got.frame_end) frame_ends++;
        if (pulse_fifo.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result %0d with none pending: pulses %h %h %h %h gap %b end %b",
                     results_seen, got.pulse[0], got.pulse[1], got.pulse[2], got.pulse[3],
                     got.gap, got.frame_end);
        end else begin
          want = pulse_fifo.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"result %0d: expected pulses %h %h %h %h gap %b end %b, ",
                        "got %h %h %h %h gap %b end %b"}, results_seen,
                       want.pulse[0], want.pulse[1], want.pulse[2], want.pulse[3],
                       want.gap, want.frame_end,
                       got.pulse[0], got.pulse[1], got.pulse[2], got.pulse[3],
                       got.gap, got.frame_end);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.kind    = kind_t'(in_ch.kind);
        seen.channel = in_ch.channel;
        seen.led     = in_ch.led_index;
        seen.green   = in_ch.green;
        seen.red     = in_ch.red;
        seen.blue    = in_ch.blue;
        items_taken++;
        step_serialiser(seen);
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               idle_cycles, pulse_fifo.size());
      $display("[ws2812_multichannel_pulse_serializer] ERROR");
      $finish;
    end
  end

  initial begin
    int len;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TICK;
    in_ch.channel   = '0;
    in_ch.led_index = '0;
    in_ch.green     = '0;
    in_ch.red       = '0;
    in_ch.blue      = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_HT_ONE;
    cfg_ch.data     = '0;
    ht_one    = HT_ONE_RST;
    ht_zero   = HT_ZERO_RST;
    strip_len = STRIP_LEN_RST;
    gap_slots = GAP_SLOTS_RST;
    in_gap    = 1'b0;
    led_pos   = 0;
    bit_pos   = 0;
    gap_count = 8'd0;
    foreach (led_colours[c, l]) led_colours[c][l] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: colour extremes on every channel, first LED partly sent
    tx_items.push_back(colour_write(0, 0, 8'hFF, 8'h00, 8'hA5));
    tx_items.push_back(colour_write(1, 0, 8'h00, 8'hFF, 8'h5A));
    tx_items.push_back(colour_write(2, 0, 8'h80, 8'h01, 8'hFE));
    tx_items.push_back(colour_write(3, 0, 8'h55, 8'hAA, 8'h0F));
    tx_items.push_back(colour_write(3, 511, 8'hFF, 8'hFF, 8'hFF));
    tx_items.push_back(colour_write(0, 511, 8'h00, 8'h00, 8'h00));
    tx_items.push_back(colour_write(1, 256, 8'h7E, 8'h81, 8'h3C));
    tx_items.push_back(colour_write(2, 1, 8'h01, 8'h80, 8'hFF));
    repeat (17) tx_items.push_back(tick());
    drain();

    // widest pulse spread, single LED, gap register zero (taken as one slot)
    set_regs(10'd255, 10'd0, 10'd1, 10'd0);
    fill_random(60, 30, 1);
    drain();

    // zero-length strip, inverted pulse widths
    set_regs(10'd0, 10'd255, 10'd0, 10'd1);
    fill_random(60, 30, 1);
    drain();

    // oversized strip and longest gap
    set_regs(10'($urandom_range(1023)), 10'($urandom_range(1023)), 10'd1023, 10'd255);
    fill_random(30, 30, 8);
    drain();

    // run well into a full-size strip; the receiver hold-off falls here
    set_regs(10'($urandom_range(255)), 10'($urandom_range(255)), 10'd512, 10'd1);
    fill_random(130, 10, 8);
    drain();

    // strip cut below the LED in flight
    set_regs(10'($urandom_range(255)), 10'($urandom_range(255)), 10'd2, 10'd2);
    fill_random(60, 30, 2);
    drain();

    steady <= 1'b1;
    set_regs(10'($urandom_range(255)), 10'($urandom_range(255)), 10'd3, 10'd1);
    fill_random(80, 30, 3);
    drain();
    steady <= 1'b0;

    repeat (6) begin
      len = $urandom_range(1, 6);
      set_regs(10'($urandom_range(1023)), 10'($urandom_range(1023)), 10'(len),
               10'($urandom_range(3)));
      fill_random(50, 30, len);
      drain();
    end

    errors += pulse_fifo.size();
    $display("summary: %0d items (%0d colour writes) over %0d register settings",
             items_taken, writes_taken, settings);
    $display("summary: %0d pulse results, %0d frame ends, %0d gap ticks, %0d mismatches",
             results_seen, frame_ends, gap_ticks, errors);
    if (errors == 0) begin
      $display("[ws2812_multichannel_pulse_serializer] OK");
    end else begin
      $display("[ws2812_multichannel_pulse_serializer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### ws2812_multichannel_pulse_serializer.f
hw/rtl/wsps_pkg.sv
hw/rtl/wsps_in_if.sv
hw/rtl/wsps_out_if.sv
hw/rtl/wsps_cfg_if.sv
hw/rtl/wsps_ram.sv
hw/rtl/wsps_cfg.sv
hw/rtl/wsps_seq.sv
hw/rtl/wsps_out.sv
hw/rtl/ws2812_multichannel_pulse_serializer.sv
dv/ws2812_multichannel_pulse_serializer_test.sv
